// ----- hdl/spa_pkg.sv -----
// Shared types, widths and constants for the spatial pan attenuation unit.
package spa_pkg;

   // Field widths of the request and response transfers
   localparam int TAG_W        = 5;
   localparam int COORD_BITS   = 16;
   localparam int GAIN_W       = 16;

   // Register widths
   localparam int VOL_W        = 16;
   localparam int DIST_W       = 32;
   localparam int SPAN_RECIP_W = 32;
   localparam int PAN_RECIP_W  = 24;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 3;

   // Internal datapath widths
   localparam int DELTA_W      = COORD_BITS + 1;
   localparam int MAG_W        = COORD_BITS + 1;
   localparam int DSQ_W        = 2 * MAG_W;
   localparam int SPLIT_W      = 16;
   localparam int DIFF_HI_W    = DSQ_W - SPLIT_W;

   // Register reset values
   localparam logic [VOL_W-1:0]        EFFECT_VOLUME_RST      = 16'd32768;
   localparam logic [DIST_W-1:0]       FALLOFF_START_RST      = 32'd60196;
   localparam logic [DIST_W-1:0]       FALLOFF_END_RST        = 32'd240784;
   localparam logic [SPAN_RECIP_W-1:0] FALLOFF_SPAN_RECIP_RST = 32'd23783;
   localparam logic [PAN_RECIP_W-1:0]  PAN_WIDTH_RECIP_RST    = 24'd78398;

   // Register indexes on the write port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_EFFECT_VOLUME      = 3'd0,
      CSR_FALLOFF_START      = 3'd1,
      CSR_FALLOFF_END        = 3'd2,
      CSR_FALLOFF_SPAN_RECIP = 3'd3,
      CSR_PAN_WIDTH_RECIP    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TAG_W-1:0]             voice_tag;
      logic signed [COORD_BITS-1:0] source_x;
      logic signed [COORD_BITS-1:0] source_y;
      logic signed [COORD_BITS-1:0] ear_x;
      logic signed [COORD_BITS-1:0] ear_y;
      logic                         is_global;
   } req_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag_out;
      logic [GAIN_W-1:0] left_gain;
      logic [GAIN_W-1:0] right_gain;
      logic              out_of_range;
   } rsp_type;

   // Per-item control carried down the pipeline
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic             is_global;
      logic             dx_neg;
      logic             dx_zero;
      logic             out_of_range;
      logic             in_unity;
   } flags_type;

endpackage

// ----- hdl/spatial_pan_attenuation_unit.sv -----
// Top level of the spatial pan attenuation unit: register file and pipeline wiring.
//
// Takes one voice per clock and returns its left and right Q1.15 gains
// through three geometry stages (deltas, squares, window tests), three
// attenuation stages (split span product, saturated ramp, square) and a
// volume stage that is also the output register. Throughput is one transfer
// per clock; every stage holds its own valid bit, so a stalled response only
// blocks the stages behind it once they fill, and bubbles are squeezed out.
// While the response side holds ready high the request side is always ready.
// Registers are written through the csr_ port; the user must do so only while
// no voice is in flight, which the block does not enforce; indexes 5 to 7 are ignored.
module spatial_pan_attenuation_unit #(
   parameter int GAIN_FRAC_BITS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  spa_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output spa_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_en,
   input  logic [spa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int GW = GAIN_FRAC_BITS + 1;

   // Configuration registers
   logic [spa_pkg::VOL_W-1:0]        effect_volume_ff;
   logic [spa_pkg::DIST_W-1:0]       falloff_start_ff;
   logic [spa_pkg::DIST_W-1:0]       falloff_end_ff;
   logic [spa_pkg::SPAN_RECIP_W-1:0] falloff_span_recip_ff;
   logic [spa_pkg::PAN_RECIP_W-1:0]  pan_width_recip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_volume_ff      <= spa_pkg::EFFECT_VOLUME_RST;
         falloff_start_ff      <= spa_pkg::FALLOFF_START_RST;
         falloff_end_ff        <= spa_pkg::FALLOFF_END_RST;
         falloff_span_recip_ff <= spa_pkg::FALLOFF_SPAN_RECIP_RST;
         pan_width_recip_ff    <= spa_pkg::PAN_WIDTH_RECIP_RST;
      end else if (csr_write_en) begin
         unique case (spa_pkg::csr_index_type'(csr_index))
            spa_pkg::CSR_EFFECT_VOLUME: begin
               effect_volume_ff <= csr_wdata[spa_pkg::VOL_W-1:0];
            end
            spa_pkg::CSR_FALLOFF_START: begin
               falloff_start_ff <= csr_wdata[spa_pkg::DIST_W-1:0];
            end
            spa_pkg::CSR_FALLOFF_END: begin
               falloff_end_ff <= csr_wdata[spa_pkg::DIST_W-1:0];
            end
            spa_pkg::CSR_FALLOFF_SPAN_RECIP: begin
               falloff_span_recip_ff <= csr_wdata[spa_pkg::SPAN_RECIP_W-1:0];
            end
            spa_pkg::CSR_PAN_WIDTH_RECIP: begin
               pan_width_recip_ff <= csr_wdata[spa_pkg::PAN_RECIP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Geometry to attenuation
   logic                      geo_valid, geo_ready;
   spa_pkg::flags_type        geo_flags;
   logic [spa_pkg::DSQ_W-1:0] geo_diff;
   logic [GW-1:0]             geo_far;

   spa_geom #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_geom (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_data        (req_data),
      .pan_width_recip(pan_width_recip_ff),
      .falloff_start  (falloff_start_ff),
      .falloff_end    (falloff_end_ff),
      .out_valid      (geo_valid),
      .out_ready      (geo_ready),
      .out_flags      (geo_flags),
      .out_diff       (geo_diff),
      .out_far        (geo_far)
   );

   // Attenuation to output stage
   logic               att_valid, att_ready;
   spa_pkg::flags_type att_flags;
   logic [GW-1:0]      att_gain, att_far;

   spa_atten #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_atten (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (geo_valid),
      .in_ready          (geo_ready),
      .in_flags          (geo_flags),
      .in_diff           (geo_diff),
      .in_far            (geo_far),
      .falloff_span_recip(falloff_span_recip_ff),
      .out_valid         (att_valid),
      .out_ready         (att_ready),
      .out_flags         (att_flags),
      .out_att           (att_gain),
      .out_far           (att_far)
   );

   spa_mix #(
      .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
   ) u_mix (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (att_valid),
      .in_ready     (att_ready),
      .in_flags     (att_flags),
      .in_att       (att_gain),
      .in_far       (att_far),
      .effect_volume(effect_volume_ff),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_data     (rsp_data)
   );

   // A silenced voice never carries a gain
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |->
         (rsp_data.left_gain == '0) && (rsp_data.right_gain == '0))
      else $error("out of range response with non-zero gain");

   // An empty output register means the whole pipeline can take a transfer
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // Reset drains the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // At or below unity volume no gain exceeds unity
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (effect_volume_ff <= spa_pkg::EFFECT_VOLUME_RST) |->
         (rsp_data.left_gain <= spa_pkg::EFFECT_VOLUME_RST)
         && (rsp_data.right_gain <= spa_pkg::EFFECT_VOLUME_RST))
      else $error("gain above unity at unity volume");

endmodule

// ----- hdl/spa_geom.sv -----
// Geometry stages: deltas, squared distance, falloff window tests and far-side pan gain.
module spa_geom #(
   parameter int GAIN_FRAC_BITS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  spa_pkg::req_type                    in_data,
   input  logic [spa_pkg::PAN_RECIP_W-1:0]     pan_width_recip,
   input  logic [spa_pkg::DIST_W-1:0]          falloff_start,
   input  logic [spa_pkg::DIST_W-1:0]          falloff_end,
   output logic                                out_valid,
   input  logic                                out_ready,
   output spa_pkg::flags_type                  out_flags,
   output logic [spa_pkg::DSQ_W-1:0]           out_diff,
   output logic [GAIN_FRAC_BITS:0]             out_far
);

   localparam int GW        = GAIN_FRAC_BITS + 1;
   localparam int PP_W      = spa_pkg::MAG_W + spa_pkg::PAN_RECIP_W;
   localparam int PAN_SHIFT = spa_pkg::PAN_RECIP_W - GAIN_FRAC_BITS;
   localparam logic [GW-1:0] ONE_GAIN = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

   // Stage enables: a stage moves when empty or when its successor moves
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Stage 1: coordinate deltas and their magnitudes
   logic signed [spa_pkg::DELTA_W-1:0] dx, dy;
   logic [spa_pkg::MAG_W-1:0]          ax_in, ay_in, ax_ff, ay_ff;
   spa_pkg::flags_type                 f1_in, f1_ff;

   always_comb begin
      dx    = spa_pkg::DELTA_W'($signed(in_data.source_x))
            - spa_pkg::DELTA_W'($signed(in_data.ear_x));
      dy    = spa_pkg::DELTA_W'($signed(in_data.source_y))
            - spa_pkg::DELTA_W'($signed(in_data.ear_y));
      ax_in = dx[spa_pkg::DELTA_W-1] ? spa_pkg::MAG_W'(-dx) : spa_pkg::MAG_W'(dx);
      ay_in = dy[spa_pkg::DELTA_W-1] ? spa_pkg::MAG_W'(-dy) : spa_pkg::MAG_W'(dy);
      f1_in.tag          = in_data.voice_tag;
      f1_in.is_global    = in_data.is_global;
      f1_in.dx_neg       = dx[spa_pkg::DELTA_W-1];
      f1_in.dx_zero      = (dx == '0);
      f1_in.out_of_range = 1'b0;
      f1_in.in_unity     = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
         f1_ff <= f1_in;
      end
   end

   // Stage 2: squares of the magnitudes and the pan slope product
   logic [spa_pkg::DSQ_W-1:0] axsq_in, aysq_in, axsq_ff, aysq_ff;
   logic [PP_W-1:0]           pan_prod_in, pan_prod_ff;
   spa_pkg::flags_type        f2_ff;

   assign axsq_in     = spa_pkg::DSQ_W'(ax_ff) * spa_pkg::DSQ_W'(ax_ff);
   assign aysq_in     = spa_pkg::DSQ_W'(ay_ff) * spa_pkg::DSQ_W'(ay_ff);
   assign pan_prod_in = PP_W'(ax_ff) * PP_W'(pan_width_recip);

   always_ff @(posedge clock) begin
      if (en2) begin
         axsq_ff     <= axsq_in;
         aysq_ff     <= aysq_in;
         pan_prod_ff <= pan_prod_in;
         f2_ff       <= f1_ff;
      end
   end

   // Stage 3: squared distance against the falloff window, far-side gain
   logic [spa_pkg::DSQ_W-1:0] dist_sq;
   logic [spa_pkg::DSQ_W-1:0] diff_in, diff_ff;
   logic [PP_W-1:0]           pan_term, one_wide;
   logic [GW-1:0]             far_in, far_ff;
   spa_pkg::flags_type        f3_in, f3_ff;

   always_comb begin
      dist_sq  = axsq_ff + aysq_ff;
      diff_in  = dist_sq - spa_pkg::DSQ_W'(falloff_start);
      pan_term = pan_prod_ff >> PAN_SHIFT;
      one_wide = PP_W'(ONE_GAIN);
      far_in   = (pan_term >= one_wide) ? '0 : GW'(one_wide - pan_term);
      f3_in    = f2_ff;
      f3_in.out_of_range = !f2_ff.is_global
                           && (dist_sq >= spa_pkg::DSQ_W'(falloff_end));
      f3_in.in_unity     = (dist_sq <= spa_pkg::DSQ_W'(falloff_start));
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         diff_ff <= diff_in;
         far_ff  <= far_in;
         f3_ff   <= f3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_flags = f3_ff;
   assign out_diff  = diff_ff;
   assign out_far   = far_ff;

endmodule

// ----- hdl/spa_atten.sv -----
// Attenuation stages: split span product, saturated ramp and its square.
module spa_atten #(
   parameter int GAIN_FRAC_BITS = 15
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  spa_pkg::flags_type                   in_flags,
   input  logic [spa_pkg::DSQ_W-1:0]            in_diff,
   input  logic [GAIN_FRAC_BITS:0]              in_far,
   input  logic [spa_pkg::SPAN_RECIP_W-1:0]     falloff_span_recip,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output spa_pkg::flags_type                   out_flags,
   output logic [GAIN_FRAC_BITS:0]              out_att,
   output logic [GAIN_FRAC_BITS:0]              out_far
);

   localparam int GW     = GAIN_FRAC_BITS + 1;
   localparam int RW     = spa_pkg::SPAN_RECIP_W;
   localparam int PHI_W  = spa_pkg::DIFF_HI_W + RW;
   localparam int PLO_W  = spa_pkg::SPLIT_W + RW;
   localparam int PROD_W = spa_pkg::DSQ_W + RW;
   localparam int SQ_W   = 2 * GW;
   localparam logic [GW-1:0] ONE_GAIN = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

   // Stage enables
   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= in_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // Stage 1: span product as two partial products over the split distance
   logic [PHI_W-1:0]   p_hi_in, p_hi_ff;
   logic [PLO_W-1:0]   p_lo_in, p_lo_ff;
   logic [GW-1:0]      far1_ff;
   spa_pkg::flags_type f1_ff;

   assign p_hi_in = PHI_W'(in_diff[spa_pkg::DSQ_W-1:spa_pkg::SPLIT_W]) * PHI_W'(falloff_span_recip);
   assign p_lo_in = PLO_W'(in_diff[spa_pkg::SPLIT_W-1:0]) * PLO_W'(falloff_span_recip);

   always_ff @(posedge clock) begin
      if (en1) begin
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         far1_ff <= in_far;
         f1_ff   <= in_flags;
      end
   end

   // Stage 2: combine partials, saturate the ramp at unity, take one minus it (unity inside the start)
   logic [PROD_W-1:0]  prod_sum;
   logic               ramp_sat;
   logic [GW-1:0]      comp_in, comp_ff;
   logic [GW-1:0]      far2_ff;
   spa_pkg::flags_type f2_ff;

   always_comb begin
      prod_sum = (PROD_W'(p_hi_ff) << spa_pkg::SPLIT_W) + PROD_W'(p_lo_ff);
      ramp_sat = |prod_sum[PROD_W-1:RW];
      if (f1_ff.in_unity) begin
         comp_in = ONE_GAIN;
      end else if (ramp_sat) begin
         comp_in = '0;
      end else begin
         comp_in = ONE_GAIN - GW'(prod_sum[RW-1 -: GAIN_FRAC_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         comp_ff <= comp_in;
         far2_ff <= far1_ff;
         f2_ff   <= f1_ff;
      end
   end

   // Stage 3: square the complement for the near-side attenuation
   logic [SQ_W-1:0]    comp_sq;
   logic [GW-1:0]      att_in, att_ff, far3_ff;
   spa_pkg::flags_type f3_ff;

   assign comp_sq = SQ_W'(comp_ff) * SQ_W'(comp_ff);
   assign att_in  = comp_sq[GAIN_FRAC_BITS +: GW];

   always_ff @(posedge clock) begin
      if (en3) begin
         att_ff  <= att_in;
         far3_ff <= far2_ff;
         f3_ff   <= f2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_flags = f3_ff;
   assign out_att   = att_ff;
   assign out_far   = far3_ff;

endmodule

// ----- hdl/spa_mix.sv -----
// Output stage: pick left and right gains and scale them by the effect volume.
module spa_mix #(
   parameter int GAIN_FRAC_BITS = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  spa_pkg::flags_type             in_flags,
   input  logic [GAIN_FRAC_BITS:0]        in_att,
   input  logic [GAIN_FRAC_BITS:0]        in_far,
   input  logic [spa_pkg::VOL_W-1:0]      effect_volume,
   output logic                           out_valid,
   input  logic                           out_ready,
   output spa_pkg::rsp_type               out_data
);

   localparam int GW   = GAIN_FRAC_BITS + 1;
   localparam int MW   = GW + spa_pkg::VOL_W;
   localparam logic [GW-1:0] ONE_GAIN = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

   logic en;
   logic valid_ff;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   // Select: global first, then silence, then near and far sides by sign of dx, unity if dx is zero
   logic [GW-1:0] left_pre, right_pre;

   always_comb begin
      priority if (in_flags.is_global) begin
         left_pre  = ONE_GAIN;
         right_pre = ONE_GAIN;
      end else if (in_flags.out_of_range || (in_att == '0)) begin
         left_pre  = '0;
         right_pre = '0;
      end else if (in_flags.dx_neg) begin
         left_pre  = in_att;
         right_pre = in_far;
      end else if (!in_flags.dx_zero) begin
         left_pre  = in_far;
         right_pre = in_att;
      end else begin
         left_pre  = ONE_GAIN;
         right_pre = ONE_GAIN;
      end
   end

   // Scale by volume and truncate to the gain field
   logic [MW-1:0]    left_prod, right_prod;
   spa_pkg::rsp_type data_in, data_ff;

   always_comb begin
      left_prod  = MW'(left_pre) * MW'(effect_volume);
      right_prod = MW'(right_pre) * MW'(effect_volume);
      data_in.tag_out      = in_flags.tag;
      data_in.left_gain    = left_prod[GAIN_FRAC_BITS +: spa_pkg::GAIN_W];
      data_in.right_gain   = right_prod[GAIN_FRAC_BITS +: spa_pkg::GAIN_W];
      data_in.out_of_range = in_flags.out_of_range;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
